FILE: sv/sevq_pkg.sv
// Shared types, constants and a helper function of the sorted event queue.
package sevq_pkg;

	localparam int CAPACITY = 64;
	localparam int TAG_W    = 16;
	localparam int DATE_W   = 48;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef enum logic [1:0] {
		KIND_SORTED  = 2'd0,
		KIND_PREPEND = 2'd1,
		KIND_APPEND  = 2'd2,
		KIND_EXTRACT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		kind_t             kind;
		logic [TAG_W-1:0]  event_tag;
		logic [DATE_W-1:0] event_date;
	} item_t;

	typedef struct packed {
		status_t           status;
		logic [TAG_W-1:0]  removed_tag;
		logic [DATE_W-1:0] removed_date;
		logic              head_valid;
		logic [TAG_W-1:0]  head_tag;
		logic [DATE_W-1:0] head_date;
		cnt_t              event_count;
	} result_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [DATE_W-1:0] date;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_HEADLD,
		S_RESP
	} fsm_state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_FULL,
		OP_EMPTY,
		OP_PREPEND,
		OP_APPEND,
		OP_INS_START,
		OP_EXTRACT,
		OP_SCAN,
		OP_PLACE,
		OP_HEADLD
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic count_zero;
		logic full;
		logic multi;
		logic greater;
		logic pos_one;
	} dp_sts_t;

	// Physical slot of a logical offset from the head pointer in the circular buffer.
	function automatic idx_t wrap_idx(idx_t base, idx_t off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IDX_W+1)'(CAPACITY)) begin
			sum = sum - (IDX_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

FILE: sv/sevq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module sevq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: sv/sevq_ctrl.sv
// Controller state machine of the sorted event queue.
module sevq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  sevq_pkg::kind_t  kind,
	input  sevq_pkg::dp_sts_t sts,
	output sevq_pkg::dp_cmd_t cmd,
	output logic             busy,
	output logic             done
);

	import sevq_pkg::*;

	fsm_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						KIND_EXTRACT: begin
							state_nxt = sts.multi ? S_HEADLD : S_RESP;
						end
						KIND_SORTED: begin
							if (sts.full || sts.count_zero) begin
								state_nxt = S_RESP;
							end else begin
								state_nxt = S_SCAN;
							end
						end
						default: begin
							state_nxt = S_RESP;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (sts.greater && sts.pos_one) begin
					state_nxt = S_PLACE;
				end else if (sts.greater) begin
					state_nxt = S_SCAN;
				end else begin
					state_nxt = S_RESP;
				end
			end
			S_PLACE:  state_nxt = S_RESP;
			S_HEADLD: state_nxt = S_RESP;
			S_RESP:   state_nxt = S_IDLE;
			default:  state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op = OP_NONE;
		busy   = (state_q != S_IDLE);
		done   = (state_q == S_RESP);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (kind)
						KIND_EXTRACT: cmd.op = sts.count_zero ? OP_EMPTY : OP_EXTRACT;
						KIND_PREPEND: cmd.op = sts.full ? OP_FULL : OP_PREPEND;
						KIND_APPEND:  cmd.op = sts.full ? OP_FULL : OP_APPEND;
						default: begin
							if (sts.full) begin
								cmd.op = OP_FULL;
							end else if (sts.count_zero) begin
								cmd.op = OP_APPEND;
							end else begin
								cmd.op = OP_INS_START;
							end
						end
					endcase
				end
			end
			S_SCAN:   cmd.op = OP_SCAN;
			S_PLACE:  cmd.op = OP_PLACE;
			S_HEADLD: cmd.op = OP_HEADLD;
			default:  cmd.op = OP_NONE;
		endcase
	end

	// The result strobe lasts exactly one cycle.
	a_resp_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP |=> state_q == S_IDLE)
		else $error("result strobe held longer than one cycle");

	// No new word can be taken while a result is on the ports.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("result strobe while idle");

	// Placing the new word at the head always ends the insert.
	a_place_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLACE |=> state_q == S_RESP)
		else $error("head placement not followed by the result");

endmodule

FILE: sv/sevq_dp.sv
// Datapath of the sorted event queue: circular buffer RAM, head copy and counters.
module sevq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  sevq_pkg::item_t   item,
	input  sevq_pkg::dp_cmd_t cmd,
	output sevq_pkg::dp_sts_t sts,
	output sevq_pkg::result_t result
);

	import sevq_pkg::*;

	cnt_t    count_q;
	idx_t    head_ptr_q;
	idx_t    pos_q;
	status_t status_q;
	entry_t  new_q;
	entry_t  head_q;
	entry_t  removed_q;

	entry_t  in_entry;
	entry_t  rdata;
	entry_t  wdata;
	logic    we;
	idx_t    waddr;
	idx_t    raddr;
	idx_t    hp_dec;
	idx_t    count_idx;
	logic    greater;
	logic    accept_op;

	assign in_entry.tag  = item.event_tag;
	assign in_entry.date = item.event_date;
	assign hp_dec    = (head_ptr_q == '0) ? idx_t'(CAPACITY - 1) : head_ptr_q - 1'b1;
	assign count_idx = count_q[IDX_W-1:0];
	assign greater   = (rdata.date > new_q.date);

	assign accept_op = (cmd.op == OP_FULL) || (cmd.op == OP_EMPTY)
		|| (cmd.op == OP_PREPEND) || (cmd.op == OP_APPEND)
		|| (cmd.op == OP_INS_START) || (cmd.op == OP_EXTRACT);

	always_comb begin
		we    = 1'b0;
		waddr = head_ptr_q;
		wdata = new_q;
		raddr = head_ptr_q;
		case (cmd.op)
			OP_PREPEND: begin
				we    = 1'b1;
				waddr = hp_dec;
				wdata = in_entry;
			end
			OP_APPEND: begin
				we    = 1'b1;
				waddr = wrap_idx(head_ptr_q, count_idx);
				wdata = in_entry;
			end
			OP_INS_START: begin
				raddr = wrap_idx(head_ptr_q, count_idx - 1'b1);
			end
			OP_EXTRACT: begin
				raddr = wrap_idx(head_ptr_q, idx_t'(1));
			end
			OP_SCAN: begin
				// Move the later word up one slot, or drop the new word into the hole.
				we    = 1'b1;
				waddr = wrap_idx(head_ptr_q, pos_q);
				wdata = greater ? rdata : new_q;
				raddr = wrap_idx(head_ptr_q, idx_t'(pos_q - idx_t'(2)));
			end
			OP_PLACE: begin
				we    = 1'b1;
				waddr = head_ptr_q;
				wdata = new_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	sevq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			head_ptr_q <= '0;
			pos_q      <= '0;
			status_q   <= ST_DONE;
		end else begin
			case (cmd.op)
				OP_FULL:  status_q <= ST_FULL;
				OP_EMPTY: status_q <= ST_EMPTY;
				OP_PREPEND: begin
					status_q   <= ST_DONE;
					head_ptr_q <= hp_dec;
					count_q    <= count_q + 1'b1;
				end
				OP_APPEND: begin
					status_q <= ST_DONE;
					count_q  <= count_q + 1'b1;
				end
				OP_INS_START: begin
					status_q <= ST_DONE;
					pos_q    <= count_idx;
					count_q  <= count_q + 1'b1;
				end
				OP_EXTRACT: begin
					status_q   <= ST_DONE;
					head_ptr_q <= wrap_idx(head_ptr_q, idx_t'(1));
					count_q    <= count_q - 1'b1;
				end
				OP_SCAN: begin
					if (greater) begin
						pos_q <= pos_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept_op) begin
			new_q     <= in_entry;
			removed_q <= (cmd.op == OP_EXTRACT) ? head_q : '0;
		end
		case (cmd.op)
			OP_PREPEND: head_q <= in_entry;
			OP_APPEND: begin
				if (count_q == '0) begin
					head_q <= in_entry;
				end
			end
			OP_PLACE:   head_q <= new_q;
			OP_HEADLD:  head_q <= rdata;
			default: begin
			end
		endcase
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.full       = (count_q == cnt_t'(CAPACITY));
	assign sts.multi      = (count_q > cnt_t'(1));
	assign sts.greater    = greater;
	assign sts.pos_one    = (pos_q == idx_t'(1));

	assign result.status       = status_q;
	assign result.removed_tag  = removed_q.tag;
	assign result.removed_date = removed_q.date;
	assign result.head_valid   = (count_q != '0);
	assign result.head_tag     = (count_q != '0) ? head_q.tag : '0;
	assign result.head_date    = (count_q != '0) ? head_q.date : '0;
	assign result.event_count  = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(CAPACITY))
		else $error("event count exceeds capacity");

	a_scan_pos: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_SCAN |-> pos_q != '0)
		else $error("insert scan reached the head slot");

	a_prepend_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_PREPEND |=> count_q == $past(count_q) + 1'b1)
		else $error("prepend did not grow the count");

	a_extract_head: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == OP_EXTRACT |=> head_ptr_q == wrap_idx($past(head_ptr_q), idx_t'(1)))
		else $error("extract did not advance the head pointer");

endmodule

FILE: sv/sorted_event_queue.sv
// Top level of the sorted event queue: controller plus datapath.
// Prepend, append, rejected inserts, empty extracts, sorted inserts into an empty queue
// and extracts that leave the queue empty give their result word in the cycle after
// start is taken; an extract leaving one or more events first passes through the
// head-load state. A sorted insert into a non-empty queue walks the stored words from
// the tail, one word per cycle through the RAM's single read port. busy is low again
// the cycle after done. Reset (arst_n low) empties the queue; the RAM is not cleared.
module sorted_event_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sevq_pkg::item_t   item,
	output logic              done,
	output sevq_pkg::result_t result
);

	import sevq_pkg::*;

	// Commands from the controller and status back from the datapath.
	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller decides on the operation from the kind of the incoming word and the
	// fill state; the datapath captures the word itself on the same accepting edge.
	sevq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath keeps the events in a circular buffer so that prepend, append and
	// extract write at most one slot and move only the head pointer and the count. A copy of
	// the head word sits in a register, so the head is reported without a RAM read.
	sevq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

endmodule
